[rtl/shift_jis_euc_jp_converter_unit_assert.svh]
// Assertion macros for the SJIS / EUC-JP converter.
// Both expect a clock named clk and a synchronous reset named rst in scope.
`ifndef SHIFT_JIS_EUC_JP_CONVERTER_UNIT_ASSERT_SVH
`define SHIFT_JIS_EUC_JP_CONVERTER_UNIT_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define SJEC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the first expression holds, the second holds in the following cycle.
`define SJEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sjec_pkg.sv]
package sjec_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_CONVERT_ENABLE = 2'd0;
  localparam logic [1:0] REG_DIRECTION      = 2'd1;

  // Queue between the classifier and the output sequencer.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Byte constants of the two encodings.
  localparam logic [7:0] SJIS_LEAD1_LO = 8'h81;
  localparam logic [7:0] SJIS_LEAD1_HI = 8'h9f;
  localparam logic [7:0] SJIS_LEAD2_LO = 8'he0;
  localparam logic [7:0] SJIS_LEAD2_HI = 8'hef;
  localparam logic [7:0] KANA_LO       = 8'ha1;
  localparam logic [7:0] KANA_HI       = 8'hdf;
  localparam logic [7:0] EUC_SS2       = 8'h8e;

  // What the classifier holds between two input items.
  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_LEAD = 2'd1,
    HELD_KANA = 2'd2
  } held_kind_t;

  // One queued job: one or two result bytes.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;
    logic       err;
  } sjec_entry_t;

  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

endpackage

[rtl/sjec_front.sv]
module sjec_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 queue_full,
  output logic                 push,
  output sjec_pkg::sjec_entry_t push_entry
);

  logic                 convert_enable;
  logic                 direction;
  sjec_pkg::held_kind_t held_kind, held_kind_next;
  logic [7:0]           held_lead, held_lead_next;
  logic                 accept;
  logic                 cfg_hit;
  logic                 produce;

  // SJIS to EUC-JP pair arithmetic, all modulo 256.
  logic [7:0] se_h1, se_h2, se_hi, se_l1, se_lo;
  // EUC-JP to SJIS pair arithmetic.
  logic [8:0] es_hsum;
  logic [7:0] es_hhalf, es_hi, es_l7, es_lt, es_lo;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign cfg_hit  = cfg_we && (cfg_index == sjec_pkg::REG_CONVERT_ENABLE ||
                               cfg_index == sjec_pkg::REG_DIRECTION);
  assign push     = accept && produce;

  always_comb begin
    se_h1 = (held_lead > sjec_pkg::SJIS_LEAD1_HI) ? held_lead - 8'h40 : held_lead;
    se_h2 = {se_h1[6:0], 1'b0};
    if (in_byte <= 8'h9e) begin
      se_hi = se_h2 - 8'he1;
      se_l1 = (in_byte >= 8'h80) ? in_byte - 8'h01 : in_byte;
      se_lo = se_l1 - 8'h1f;
    end else begin
      se_hi = se_h2 - 8'he0;
      se_l1 = in_byte;
      se_lo = in_byte - 8'h7e;
    end

    es_hsum  = {2'b00, held_lead[6:0]} + 9'h0e1;
    es_hhalf = es_hsum[8:1];
    es_hi    = (es_hhalf > 8'h9f) ? es_hhalf + 8'h40 : es_hhalf;
    es_l7    = {1'b0, in_byte[6:0]};
    es_lt    = es_l7 + 8'h1f;
    if (held_lead[0]) begin
      es_lo = (es_lt > 8'h7e) ? es_lt + 8'h01 : es_lt;
    end else begin
      es_lo = es_l7 + 8'h7e;
    end
  end

  // Classification of the incoming byte against the held state.
  always_comb begin
    held_kind_next  = sjec_pkg::HELD_NONE;
    held_lead_next  = 8'h00;
    produce         = 1'b1;
    push_entry.b0   = in_byte;
    push_entry.b1   = 8'h00;
    push_entry.two  = 1'b0;
    push_entry.err  = 1'b0;
    if (!convert_enable) begin
      produce = 1'b1;
    end else if (!direction) begin
      case (held_kind)
        sjec_pkg::HELD_LEAD: begin
          push_entry.b0  = se_hi | 8'h80;
          push_entry.b1  = se_lo | 8'h80;
          push_entry.two = 1'b1;
        end
        default: begin
          if (!in_byte[7]) begin
            produce = 1'b1;
          end else if (in_byte inside {[sjec_pkg::SJIS_LEAD1_LO:sjec_pkg::SJIS_LEAD1_HI],
                                       [sjec_pkg::SJIS_LEAD2_LO:sjec_pkg::SJIS_LEAD2_HI]}) begin
            produce        = 1'b0;
            held_kind_next = sjec_pkg::HELD_LEAD;
            held_lead_next = in_byte;
          end else if (in_byte inside {[sjec_pkg::KANA_LO:sjec_pkg::KANA_HI]}) begin
            push_entry.b0  = sjec_pkg::EUC_SS2;
            push_entry.b1  = in_byte;
            push_entry.two = 1'b1;
          end else begin
            push_entry.b0  = 8'h00;
            push_entry.err = 1'b1;
          end
        end
      endcase
    end else begin
      case (held_kind)
        sjec_pkg::HELD_KANA: begin
          push_entry.b0 = in_byte | 8'h80;
        end
        sjec_pkg::HELD_LEAD: begin
          push_entry.b0  = es_hi;
          push_entry.b1  = es_lo;
          push_entry.two = 1'b1;
        end
        default: begin
          if (!in_byte[7]) begin
            produce = 1'b1;
          end else if (in_byte == sjec_pkg::EUC_SS2) begin
            produce        = 1'b0;
            held_kind_next = sjec_pkg::HELD_KANA;
          end else begin
            produce        = 1'b0;
            held_kind_next = sjec_pkg::HELD_LEAD;
            held_lead_next = in_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      convert_enable <= 1'b0;
      direction      <= 1'b0;
      held_kind      <= sjec_pkg::HELD_NONE;
      held_lead      <= 8'h00;
    end else if (cfg_we) begin
      if (cfg_index == sjec_pkg::REG_CONVERT_ENABLE) begin
        convert_enable <= cfg_data;
      end
      if (cfg_index == sjec_pkg::REG_DIRECTION) begin
        direction <= cfg_data;
      end
      if (cfg_hit) begin
        held_kind <= sjec_pkg::HELD_NONE;
        held_lead <= 8'h00;
      end
    end else if (accept) begin
      held_kind <= held_kind_next;
      held_lead <= held_lead_next;
    end
  end

endmodule

[rtl/sjec_queue.sv]
module sjec_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sjec_pkg::sjec_entry_t   push_entry,
  input  logic                    pop,
  output sjec_pkg::sjec_entry_t   head,
  output sjec_pkg::queue_status_t status
);

  sjec_pkg::sjec_entry_t                 slots [sjec_pkg::QUEUE_DEPTH];
  logic [sjec_pkg::QUEUE_PTR_W-1:0]      wr_ptr;
  logic [sjec_pkg::QUEUE_PTR_W-1:0]      rd_ptr;
  logic [sjec_pkg::QUEUE_CNT_W-1:0]      count;

  assign head         = slots[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == sjec_pkg::QUEUE_CNT_W'(sjec_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/sjec_back.sv]
module sjec_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  queue_empty,
  input  sjec_pkg::sjec_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  last,
  output logic                  error
);

  sjec_pkg::sjec_entry_t cur;
  logic                  cur_valid;
  logic                  phase;
  logic                  done;

  assign out_valid = cur_valid;
  assign out_byte  = phase ? cur.b1 : cur.b0;
  assign last      = phase || !cur.two;
  assign error     = cur.err;

  // The current job ends when its last byte is taken.
  assign done = cur_valid && out_ready && last;
  assign pop  = !queue_empty && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      phase     <= 1'b0;
    end else if (done) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (cur_valid && out_ready) begin
      phase <= 1'b1;
    end
  end

endmodule

[rtl/shift_jis_euc_jp_converter_unit.sv]
// SJIS / EUC-JP byte-stream converter. One source byte is taken per cycle on the
// in_valid/in_ready channel and turned into zero, one or two result items on the
// out_valid/out_ready channel; last marks the final item caused by an input byte, and
// error marks an invalid SJIS high byte, which yields a single zero byte. A lead
// byte gives no item of its own: it is held until its trail byte arrives. Register 0
// (convert_enable) selects pass-through or conversion, register 1 (direction) selects
// SJIS to EUC-JP (0) or EUC-JP to SJIS (1); a write to either clears any held
// lead byte, and writes are expected only while the block is idle. Input bytes are
// accepted at one per cycle as long as the four-entry job queue has room; the output
// sequencer drains one result item per cycle while out_ready is high, so a long run of
// characters that expand to two bytes fills the queue and then holds in_ready low
// until the queue has room again. The first result item of an input byte is written
// into the job queue and then loaded into the sequencer's current-job register before
// it is presented on the out_valid/out_ready channel.
module shift_jis_euc_jp_converter_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       error
);

  `include "shift_jis_euc_jp_converter_unit_assert.svh"

  sjec_pkg::sjec_entry_t   push_entry;
  sjec_pkg::sjec_entry_t   head;
  sjec_pkg::queue_status_t queue_stat;
  logic                    push;
  logic                    pop;
  logic                    err_item_ok;
  logic                    queue_in_bounds;
  logic                    first_of_pair;

  // The classifier keeps the configuration and the held lead byte, and pushes one
  // job per input byte that produces output.
  sjec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .queue_full (queue_stat.full),
    .push       (push),
    .push_entry (push_entry)
  );

  // The queue lets the input keep flowing while the output side is stalled.
  sjec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (queue_stat)
  );

  // The sequencer holds the current job and emits its one or two bytes.
  sjec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_stat.empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last        (last),
    .error       (error)
  );

  assign err_item_ok     = !(out_valid && error) || (out_byte == 8'h00 && last);
  assign queue_in_bounds = queue_stat.count <= sjec_pkg::QUEUE_CNT_W'(sjec_pkg::QUEUE_DEPTH);
  assign first_of_pair   = out_valid && out_ready && !last;

  // An error item is always a single zero byte.
  `SJEC_ASSERT_ALWAYS(a_err_single, err_item_ok, "error item must be a lone zero byte")

  // The queue never holds more jobs than it has slots.
  `SJEC_ASSERT_ALWAYS(a_queue_bound, queue_in_bounds, "queue count beyond depth")

  // Once the first byte of a pair is taken, the second follows at once.
  `SJEC_ASSERT_NEXT(a_pair_follow, first_of_pair, out_valid && !error, "pair second byte missing")

endmodule
